[rtl/core/dtr_pkg.sv]
// Package for the divider/timer block with delayed reload.
// Holds request and register codes, packing widths and the tap table.
// No dependencies.
package dtr_pkg;

   // request kinds
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // register selects
   localparam logic [1:0] SEL_DIVIDER = 2'd0;
   localparam logic [1:0] SEL_COUNTER = 2'd1;
   localparam logic [1:0] SEL_MODULO  = 2'd2;
   localparam logic [1:0] SEL_CONTROL = 2'd3;

   localparam int DIV_W   = 16;
   localparam int BYTE_W  = 8;
   localparam int TAP_W   = 4;
   localparam int COUNT_W = 4;

   // reload countdown: starts at 8, reload happens once it drops to 4 or less
   localparam logic [COUNT_W-1:0] RELOAD_START = 4'd8;
   localparam logic [COUNT_W-1:0] RELOAD_LAST  = 4'd4;

   // control byte layout
   localparam int CTRL_ENABLE_BIT = 2;

   // stream packing
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TDATA_W = 16;

   // divider bit watched for each clock select code
   function automatic logic [TAP_W-1:0] tap_of(input logic [1:0] clk_sel);
      logic [TAP_W-1:0] tap;
      case (clk_sel)
         2'd0:    tap = 4'd9;
         2'd1:    tap = 4'd3;
         2'd2:    tap = 4'd5;
         default: tap = 4'd7;
      endcase
      return tap;
   endfunction

endpackage

[rtl/core/divider_timer_with_reload_delay.sv]
// Divider/timer with delayed counter reload and interrupt flag; depends on dtr_pkg.
// The result of an item is presented in the cycle after it is accepted.
// Throughput: one item per cycle; the state update and the result are formed
// in the acceptance cycle and the result sits in one output register.
// req_tready drops only while that output register is full and not taken.
// Synchronous active-high reset clears all state but the output data and irq registers, and empties the output.
module divider_timer_with_reload_delay (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] write_data
   input  logic [3:0]  req_tuser,   // [1:0] req_type, [3:2] reg_sel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] read_data, [8] irq, [15:9] zero
);

   logic [dtr_pkg::DIV_W-1:0]   divider_ff,   divider_in;
   logic [dtr_pkg::BYTE_W-1:0]  counter_ff,   counter_in;
   logic [dtr_pkg::BYTE_W-1:0]  modulo_ff,    modulo_in;
   logic [dtr_pkg::BYTE_W-1:0]  control_ff,   control_in;
   logic [dtr_pkg::TAP_W-1:0]   tap_ff,       tap_in;
   logic                        enabled_ff,   enabled_in;
   logic [dtr_pkg::COUNT_W-1:0] countdown_ff, countdown_in;

   logic                        out_valid_ff;
   logic [dtr_pkg::BYTE_W-1:0]  out_data_ff,  out_data_in;
   logic                        out_irq_ff,   out_irq_in;

   logic [1:0]                  req_kind;
   logic [1:0]                  reg_sel;
   logic [dtr_pkg::BYTE_W-1:0]  wdata;
   logic                        accept;

   logic [dtr_pkg::TAP_W-1:0]   new_tap;
   logic                        new_en;
   logic                        old_in;
   logic                        new_in;

   assign req_kind = req_tuser[1:0];
   assign reg_sel  = req_tuser[3:2];
   assign wdata    = req_tdata;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_irq_ff, out_data_ff};

   assign new_tap = dtr_pkg::tap_of(wdata[1:0]);
   assign new_en  = wdata[dtr_pkg::CTRL_ENABLE_BIT];
   assign old_in  = enabled_ff && divider_ff[tap_ff];
   assign new_in  = new_en && divider_ff[new_tap];

   always_comb begin
      divider_in   = divider_ff;
      counter_in   = counter_ff;
      modulo_in    = modulo_ff;
      control_in   = control_ff;
      tap_in       = tap_ff;
      enabled_in   = enabled_ff;
      countdown_in = countdown_ff;
      out_data_in  = '0;
      out_irq_in   = 1'b0;

      case (req_kind)
         dtr_pkg::REQ_TICK: begin
            if (countdown_ff != '0) begin
               countdown_in = countdown_ff - 1'b1;
               if (countdown_in <= dtr_pkg::RELOAD_LAST) begin
                  counter_in = modulo_ff;
                  out_irq_in = 1'b1;
               end
            end
            divider_in = divider_ff + 1'b1;
            // while enabled, a falling edge of the watched divider bit steps the counter
            if (enabled_ff && divider_ff[tap_ff] && !divider_in[tap_ff]) begin
               counter_in = counter_in + 1'b1;
               if (counter_in == '0)
                  countdown_in = dtr_pkg::RELOAD_START;
            end
         end
         dtr_pkg::REQ_WRITE: begin
            case (reg_sel)
               dtr_pkg::SEL_DIVIDER: begin
                  divider_in = '0;
                  if (enabled_ff && divider_ff[tap_ff]) begin
                     counter_in = counter_ff + 1'b1;
                     if (counter_in == '0)
                        countdown_in = dtr_pkg::RELOAD_START;
                  end
               end
               dtr_pkg::SEL_COUNTER: begin
                  // cancel window clears the pending reload; reload window drops the write
                  if (countdown_ff > dtr_pkg::RELOAD_LAST)
                     countdown_in = '0;
                  if (countdown_in == '0)
                     counter_in = wdata;
               end
               dtr_pkg::SEL_MODULO: begin
                  modulo_in = wdata;
               end
               default: begin
                  // mux glitch: overflow here reloads and interrupts at once
                  if (old_in && !new_in) begin
                     counter_in = counter_ff + 1'b1;
                     if (counter_in == '0) begin
                        counter_in = modulo_ff;
                        out_irq_in = 1'b1;
                     end
                  end
                  control_in = wdata;
                  enabled_in = new_en;
                  tap_in     = new_tap;
               end
            endcase
         end
         dtr_pkg::REQ_READ: begin
            case (reg_sel)
               dtr_pkg::SEL_DIVIDER: out_data_in = divider_ff[dtr_pkg::DIV_W-1 -: dtr_pkg::BYTE_W];
               dtr_pkg::SEL_COUNTER: out_data_in = counter_ff;
               dtr_pkg::SEL_MODULO:  out_data_in = modulo_ff;
               default:              out_data_in = control_ff;
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff   <= '0;
         counter_ff   <= '0;
         modulo_ff    <= '0;
         control_ff   <= '0;
         tap_ff       <= '0;
         enabled_ff   <= 1'b0;
         countdown_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            divider_ff   <= divider_in;
            counter_ff   <= counter_in;
            modulo_ff    <= modulo_in;
            control_ff   <= control_in;
            tap_ff       <= tap_in;
            enabled_ff   <= enabled_in;
            countdown_ff <= countdown_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_data_ff <= out_data_in;
         out_irq_ff  <= out_irq_in;
      end
   end

   a_countdown_range: assert property (@(posedge clock) disable iff (reset)
      countdown_ff <= dtr_pkg::RELOAD_START)
      else $error("reload countdown above start value");

   // the reloaded counter may still step on the same tick, so only the flag is checked
   a_reload_irq: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == dtr_pkg::REQ_TICK && countdown_ff != '0
         && countdown_ff <= (dtr_pkg::RELOAD_LAST + 1'b1)
      |=> rsp_tvalid && rsp_tdata[8])
      else $error("tick in reload window did not reload and interrupt");

   a_counter_write_blocked: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == dtr_pkg::REQ_WRITE && reg_sel == dtr_pkg::SEL_COUNTER
         && countdown_ff != '0 && countdown_ff <= dtr_pkg::RELOAD_LAST
      |=> $stable(counter_ff))
      else $error("counter write in reload window took effect");

   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind != dtr_pkg::REQ_READ |=> rsp_tdata[7:0] == '0)
      else $error("read data nonzero for a non-read item");

endmodule
